// ===== rtl/fct_pkg.sv =====
// ----------------------------------------------------------------------------
// fct_pkg
// Shared types and constants for the six-plane frustum culling block.
// ----------------------------------------------------------------------------
package fct_pkg;

  localparam int PLANE_COUNT = 6;

  localparam int COORD_W  = 16;
  localparam int HALF_W   = 15;
  localparam int SLOT_W   = 3;
  localparam int NEAR_W   = 19;
  localparam int PROD_W   = 2 * COORD_W;          // signed normal times coordinate
  localparam int MAG_W    = COORD_W + HALF_W;     // |normal| times half size
  localparam int FRAC_SH  = 14;                   // Q2.14 normal scale
  localparam int SUM_W    = 35;                   // plane value plus margin, no overflow
  localparam int FLOOR_W  = SUM_W - FRAC_SH;

  localparam logic signed [NEAR_W-1:0] NEAR_CULLED = -19'sd256;
  localparam logic signed [NEAR_W-1:0] NEAR_MAX    = 19'sh3FFFF;
  localparam logic signed [NEAR_W-1:0] NEAR_MIN    = 19'sh40000;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_POINT  = 2'd1,
    OP_SPHERE = 2'd2,
    OP_BOX    = 2'd3
  } opcode_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] d;
    logic signed [COORD_W-1:0] nz;
    logic signed [COORD_W-1:0] ny;
    logic signed [COORD_W-1:0] nx;
  } plane_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    plane_t            plane;
  } plane_wr_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic [HALF_W-1:0]         hx;
    logic [HALF_W-1:0]         hy;
    logic [HALF_W-1:0]         hz;
  } obj_t;

  typedef struct packed {
    opcode_t                   op;
    logic signed [COORD_W-1:0] w;
  } s2_info_t;

endpackage

// ===== rtl/fct_if.sv =====
// ----------------------------------------------------------------------------
// fct_if
// Valid/ready channels for object items and culling results.
// ----------------------------------------------------------------------------
interface fct_item_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           opcode;
  logic [fct_pkg::SLOT_W-1:0]           plane_slot;
  logic signed [fct_pkg::COORD_W-1:0]   vec_x;
  logic signed [fct_pkg::COORD_W-1:0]   vec_y;
  logic signed [fct_pkg::COORD_W-1:0]   vec_z;
  logic signed [fct_pkg::COORD_W-1:0]   scalar_w;
  logic [fct_pkg::HALF_W-1:0]           half_x;
  logic [fct_pkg::HALF_W-1:0]           half_y;
  logic [fct_pkg::HALF_W-1:0]           half_z;

  modport source (output valid, opcode, plane_slot, vec_x, vec_y, vec_z, scalar_w,
                  half_x, half_y, half_z, input ready);
  modport sink   (input valid, opcode, plane_slot, vec_x, vec_y, vec_z, scalar_w,
                  half_x, half_y, half_z, output ready);
endinterface

interface fct_result_if;
  logic                                valid;
  logic                                ready;
  logic                                visible;
  logic signed [fct_pkg::NEAR_W-1:0]   near_distance;

  modport source (output valid, visible, near_distance, input ready);
  modport sink   (input valid, visible, near_distance, output ready);
endinterface

// ===== rtl/fct_plane_store.sv =====
// ----------------------------------------------------------------------------
// fct_plane_store
// Register file holding the clip planes; every plane is read in parallel.
// ----------------------------------------------------------------------------
module fct_plane_store (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  fct_pkg::plane_wr_t                           wr,
  output fct_pkg::plane_t [fct_pkg::PLANE_COUNT-1:0]   planes
);
  import fct_pkg::*;

  plane_t [PLANE_COUNT-1:0] planes_r;
  plane_t [PLANE_COUNT-1:0] planes_nxt;

  // A slot number past the last plane matches no entry and is dropped.
  always_comb begin
    planes_nxt = planes_r;
    for (int i = 0; i < PLANE_COUNT; i++) begin
      if (wr.en && (32'(wr.slot) == i)) begin
        planes_nxt[i] = wr.plane;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      planes_r <= '0;
    end else begin
      planes_r <= planes_nxt;
    end
  end

  assign planes = planes_r;

endmodule

// ===== rtl/fct_lane.sv =====
// ----------------------------------------------------------------------------
// fct_lane
// One plane test: registered products, then plane value and cull decision.
// ----------------------------------------------------------------------------
module fct_lane (
  input  logic                                clk,
  input  logic                                load,
  input  fct_pkg::plane_t                     plane,
  input  fct_pkg::obj_t                       obj,
  input  fct_pkg::s2_info_t                   info,
  output logic                                cull,
  output logic signed [fct_pkg::SUM_W-1:0]    s_val
);
  import fct_pkg::*;

  logic signed [PROD_W-1:0]  px_r, py_r, pz_r;
  logic signed [PROD_W-1:0]  px_nxt, py_nxt, pz_nxt;
  logic [MAG_W-1:0]          mx_r, my_r, mz_r;
  logic [MAG_W-1:0]          mx_nxt, my_nxt, mz_nxt;
  logic signed [COORD_W-1:0] d_r;
  logic [COORD_W-1:0]        abs_x, abs_y, abs_z;
  logic signed [SUM_W-1:0]   d_term, w_term, m_term;
  logic signed [SUM_W-1:0]   sphere_sum, box_sum;
  logic [MAG_W+1:0]          m_sum;

  // The magnitude of -1.0 in Q2.14 still fits 16 unsigned bits.
  assign abs_x = plane.nx[COORD_W-1] ? (~plane.nx + 1'b1) : plane.nx;
  assign abs_y = plane.ny[COORD_W-1] ? (~plane.ny + 1'b1) : plane.ny;
  assign abs_z = plane.nz[COORD_W-1] ? (~plane.nz + 1'b1) : plane.nz;

  assign px_nxt = plane.nx * obj.cx;
  assign py_nxt = plane.ny * obj.cy;
  assign pz_nxt = plane.nz * obj.cz;
  assign mx_nxt = abs_x * obj.hx;
  assign my_nxt = abs_y * obj.hy;
  assign mz_nxt = abs_z * obj.hz;

  always_ff @(posedge clk) begin
    if (load) begin
      px_r <= px_nxt;
      py_r <= py_nxt;
      pz_r <= pz_nxt;
      mx_r <= mx_nxt;
      my_r <= my_nxt;
      mz_r <= mz_nxt;
      d_r  <= plane.d;
    end
  end

  assign d_term = $signed({{(SUM_W-COORD_W-FRAC_SH){d_r[COORD_W-1]}}, d_r,
                           {FRAC_SH{1'b0}}});
  assign w_term = $signed({{(SUM_W-COORD_W-FRAC_SH){info.w[COORD_W-1]}}, info.w,
                           {FRAC_SH{1'b0}}});
  assign m_sum  = (MAG_W+2)'(mx_r) + (MAG_W+2)'(my_r) + (MAG_W+2)'(mz_r);
  assign m_term = $signed(SUM_W'(m_sum));

  assign s_val      = SUM_W'(px_r) + SUM_W'(py_r) + SUM_W'(pz_r) + d_term;
  assign sphere_sum = s_val + w_term;
  assign box_sum    = s_val + m_term;

  always_comb begin
    unique case (info.op)
      OP_POINT:  cull = (s_val <= 0);
      OP_SPHERE: cull = (sphere_sum <= 0);
      OP_BOX:    cull = box_sum[SUM_W-1];
      default:   cull = 1'b0;
    endcase
  end

endmodule

// ===== rtl/frustum_culling_test.sv =====
// ----------------------------------------------------------------------------
// frustum_culling_test
// Six-plane view frustum culling of points, spheres and boxes in fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   in_item carries one transaction per object or plane load. Opcode write
//   loads plane_slot with a Q2.14 normal and a Q8.8 distance; the point,
//   sphere and box opcodes test an object against all planes at once.
//   out_result returns one transaction per input: the visible flag and the
//   near-plane distance (plane slot five; zero for box and write items) in Q11.8.
//   Each result passes the input register, the product register and the
//   result register in turn before it is presented.
//   Throughput: one item per cycle while out_result is ready. Each plane
//   has its own lane of six multipliers, so every plane is evaluated in
//   the same product stage. A plane load takes effect for the very next item.
//   Reset clears the pipeline valid bits and sets every plane to zero.
//   When out_result stalls, the three stages fill up and bubbles collapse;
//   in_item.ready drops only once all three stages hold an item.
// ----------------------------------------------------------------------------
module frustum_culling_test (
  input  logic         clk,
  input  logic         rst_n,
  fct_item_if.sink     in_item,
  fct_result_if.source out_result
);
  import fct_pkg::*;

  // Stage one: input register.
  logic      s1_valid_r, s1_valid_nxt;
  opcode_t   s1_op_r;
  logic signed [COORD_W-1:0] s1_w_r;
  obj_t      s1_obj_r;
  // Stage two: lane product registers plus this side information.
  logic      s2_valid_r, s2_valid_nxt;
  s2_info_t  s2_info_r;
  // Stage three: result register.
  logic      out_valid_r, out_valid_nxt;
  logic      out_visible_r, out_visible_nxt;
  logic signed [NEAR_W-1:0] out_near_r, out_near_nxt;

  logic s1_ready, s2_ready, s3_ready;
  logic in_accept, s2_load, s3_load;

  plane_wr_t                    plane_wr;
  plane_t [PLANE_COUNT-1:0]     planes;
  logic   [PLANE_COUNT-1:0]     lane_cull;
  logic signed [SUM_W-1:0]      lane_s [PLANE_COUNT];
  logic signed [FLOOR_W-1:0]    near_floor;
  logic signed [NEAR_W-1:0]     near_sat;
  logic                         any_cull;

  assign s3_ready  = !out_valid_r || out_result.ready;
  assign s2_ready  = !s2_valid_r || s3_ready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign in_accept = in_item.valid && s1_ready;
  assign s2_load   = s1_valid_r && s2_ready;
  assign s3_load   = s2_valid_r && s3_ready;

  assign in_item.ready = s1_ready;

  // Planes are written as the item is taken, so older tests in flight have
  // already captured their products from the previous contents.
  assign plane_wr.en          = in_accept && (opcode_t'(in_item.opcode) == OP_WRITE);
  assign plane_wr.slot        = in_item.plane_slot;
  assign plane_wr.plane.nx    = in_item.vec_x;
  assign plane_wr.plane.ny    = in_item.vec_y;
  assign plane_wr.plane.nz    = in_item.vec_z;
  assign plane_wr.plane.d     = in_item.scalar_w;

  fct_plane_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (plane_wr),
    .planes (planes)
  );

  for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_lane
    fct_lane u_lane (
      .clk   (clk),
      .load  (s2_load),
      .plane (planes[i]),
      .obj   (s1_obj_r),
      .info  (s2_info_r),
      .cull  (lane_cull[i]),
      .s_val (lane_s[i])
    );
  end

  assign s1_valid_nxt  = s1_ready ? in_item.valid : s1_valid_r;
  assign s2_valid_nxt  = s2_ready ? s1_valid_r : s2_valid_r;
  assign out_valid_nxt = s3_ready ? s2_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op_r     <= opcode_t'(in_item.opcode);
      s1_w_r      <= in_item.scalar_w;
      s1_obj_r.cx <= in_item.vec_x;
      s1_obj_r.cy <= in_item.vec_y;
      s1_obj_r.cz <= in_item.vec_z;
      s1_obj_r.hx <= in_item.half_x;
      s1_obj_r.hy <= in_item.half_y;
      s1_obj_r.hz <= in_item.half_z;
    end
    if (s2_load) begin
      s2_info_r.op <= s1_op_r;
      s2_info_r.w  <= s1_w_r;
    end
    if (s3_load) begin
      out_visible_r <= out_visible_nxt;
      out_near_r    <= out_near_nxt;
    end
  end

  // Floor from Q.22 to eight fraction bits is an arithmetic shift; then clamp to 19-bit Q11.8.
  assign near_floor = lane_s[PLANE_COUNT-1][SUM_W-1:FRAC_SH];
  always_comb begin
    if (near_floor[FLOOR_W-1:NEAR_W-1] == '0 || near_floor[FLOOR_W-1:NEAR_W-1] == '1) begin
      near_sat = near_floor[NEAR_W-1:0];
    end else if (near_floor[FLOOR_W-1]) begin
      near_sat = NEAR_MIN;
    end else begin
      near_sat = NEAR_MAX;
    end
  end

  assign any_cull = |lane_cull;

  always_comb begin
    unique case (s2_info_r.op)
      OP_WRITE: begin
        out_visible_nxt = 1'b0;
        out_near_nxt    = '0;
      end
      OP_BOX: begin
        out_visible_nxt = !any_cull;
        out_near_nxt    = '0;
      end
      default: begin
        out_visible_nxt = !any_cull;
        out_near_nxt    = any_cull ? NEAR_CULLED : near_sat;
      end
    endcase
  end

  assign out_result.valid         = out_valid_r;
  assign out_result.visible       = out_visible_r;
  assign out_result.near_distance = out_near_r;

  // A write to a slot past the last plane must leave every plane untouched.
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && opcode_t'(in_item.opcode) == OP_WRITE &&
     32'(in_item.plane_slot) >= PLANE_COUNT) |=> $stable(planes))
    else $error("plane store changed on an out-of-range slot write");

  // The plane store comes out of reset empty.
  a_reset_planes: assert property (@(posedge clk)
    $past(!rst_n) |-> (planes == '0))
    else $error("plane store not cleared by reset");

  // A stalled middle stage keeps its item.
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !s3_ready) |=> s2_valid_r)
    else $error("middle stage lost an item while stalled");

  // A hidden result carries either zero or the culled marker distance.
  a_culled_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_visible_r) |-> (out_near_r == '0 || out_near_r == NEAR_CULLED))
    else $error("culled result with an unexpected distance");

endmodule
